[sv/blocked_bloom_filter_assert.svh]
// assertion macros for the blocked bloom filter
`ifndef BLOCKED_BLOOM_FILTER_ASSERT_SVH
`define BLOCKED_BLOOM_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define BBF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBF_ASSERT(label, clk, rst, prop, msg)
`define BBF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[sv/bbf_pkg.sv]
// shared constants for the blocked bloom filter
package bbf_pkg;
   localparam int DEF_MAX_BLOCKS       = 1024;
   localparam int DEF_BLOCK_SIZE_BYTES = 64;
   localparam int DEF_MAX_HASHES       = 16;

   localparam int NB_W       = 11;
   localparam int NH_W       = 5;
   localparam int KCNT_W     = 6;
   localparam int KEY_W      = 64;
   localparam int HALF_W     = 32;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_C2     = 64'h94d049bb133111eb;
   localparam logic [63:0] SEED_BLOCK = 64'h123456789abcdef0;
   localparam logic [63:0] SEED_BITS  = 64'hfedcba9876543210;

   // reciprocal for the bit position reduction
   localparam int RECIP_SHIFT = 40;
   localparam int RECIP_W     = 35;

   localparam logic REG_NUM_BLOCKS = 1'b0;
   localparam logic REG_NUM_HASHES = 1'b1;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;
endpackage

[sv/bbf_fifo.sv]
// two-entry word queue
module bbf_fifo #(
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   logic [DATA_W-1:0] slot_ff [2];
   logic              wp_ff, rp_ff;
   logic [1:0]        cnt_ff;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wp_ff <= !wp_ff;
         end
         if (do_pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule

[sv/bbf_front.sv]
// front end: key hashing and block selection
module bbf_front #(
   parameter int MAX_BLOCKS       = 1024,
   parameter int BLOCK_SIZE_BYTES = 64,
   parameter int ENT_W            = 79
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    mode,
   input  logic [63:0]             key,
   input  logic [bbf_pkg::NB_W-1:0] nb_eff,
   output logic                    busy,
   output logic                    ent_push,
   input  logic                    ent_full,
   output logic [ENT_W-1:0]        ent_data
);
   import bbf_pkg::*;

   localparam int WPB         = (BLOCK_SIZE_BYTES + 7) / 8;
   localparam int STORE_WORDS = MAX_BLOCKS * WPB;
   localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_DIV  = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic                 mode_ff;
   logic [63:0]          key_ff;
   logic [63:0]          a_ff, a_in, acc_ff, acc_in;
   logic [1:0]           ph_ff, ph_in;
   logic                 msel_ff, msel_in, hsel_ff, hsel_in;
   logic [63:0]          h1_ff, h1_in, h2_ff, h2_in;
   logic [63:0]          divd_ff, divd_in;
   logic [NB_W:0]        rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [NB_W-1:0]      div_ff, div_in;
   logic                 zero_ff, zero_in;
   logic [AW-1:0]        base_ff, base_in;

   logic [63:0] mconst, prod, z0, a0, seed, key_src, hfin;
   logic [31:0] mul_a, mul_b;
   logic [NB_W:0] r_sh, rem_next;

   assign busy     = (state_ff != F_IDLE);
   assign ent_push = (state_ff == F_PUSH) && !ent_full;
   assign ent_data = {mode_ff, zero_ff, base_ff, h2_ff[31:0], h2_ff[63:32] | 32'd1};

   always_comb begin
      mconst = msel_ff ? MIX_C2 : MIX_C1;
      case (ph_ff)
         2'd0: begin
            mul_a = a_ff[31:0];
            mul_b = mconst[31:0];
         end
         2'd1: begin
            mul_a = a_ff[63:32];
            mul_b = mconst[31:0];
         end
         default: begin
            mul_a = a_ff[31:0];
            mul_b = mconst[63:32];
         end
      endcase
      prod   = 64'(mul_a) * 64'(mul_b);
      acc_in = (ph_ff == 2'd0) ? prod : acc_ff + {prod[31:0], 32'd0};
      hfin   = acc_in ^ (acc_in >> 31);
      // seed mix of the first or the second hash
      seed    = (state_ff == F_IDLE) ? SEED_BLOCK : SEED_BITS;
      key_src = (state_ff == F_IDLE) ? key : key_ff;
      z0      = (key_src ^ seed) + MIX_GOLDEN;
      a0      = z0 ^ (z0 >> 30);
      // restoring division, one quotient bit a cycle
      r_sh     = {rem_ff[NB_W-1:0], divd_ff[63]};
      rem_next = (r_sh >= {1'b0, div_ff}) ? r_sh - {1'b0, div_ff} : r_sh;
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      ph_in    = ph_ff;
      msel_in  = msel_ff;
      hsel_in  = hsel_ff;
      h1_in    = h1_ff;
      h2_in    = h2_ff;
      divd_in  = divd_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      div_in   = div_ff;
      zero_in  = zero_ff;
      base_in  = base_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               a_in     = a0;
               ph_in    = 2'd0;
               msel_in  = 1'b0;
               hsel_in  = 1'b0;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            if (ph_ff != 2'd2) begin
               ph_in = ph_ff + 2'd1;
            end else begin
               ph_in = 2'd0;
               if (!msel_ff) begin
                  a_in    = acc_in ^ (acc_in >> 27);
                  msel_in = 1'b1;
               end else if (!hsel_ff) begin
                  h1_in   = hfin;
                  a_in    = a0;
                  msel_in = 1'b0;
                  hsel_in = 1'b1;
               end else begin
                  h2_in   = hfin;
                  msel_in = 1'b0;
                  hsel_in = 1'b0;
                  if (nb_eff == '0) begin
                     zero_in  = 1'b1;
                     base_in  = '0;
                     state_in = F_PUSH;
                  end else begin
                     zero_in  = 1'b0;
                     divd_in  = h1_ff;
                     rem_in   = '0;
                     dcnt_in  = '0;
                     div_in   = nb_eff;
                     state_in = F_DIV;
                  end
               end
            end
         end
         F_DIV: begin
            divd_in = divd_ff << 1;
            rem_in  = rem_next;
            dcnt_in = dcnt_ff + DIV_CNT_W'(1);
            if (dcnt_ff == '1) begin
               base_in  = AW'(32'(rem_next[NB_W-1:0]) * WPB);
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!ent_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && state_ff == F_IDLE) begin
         mode_ff <= mode;
         key_ff  <= key;
      end
      a_ff    <= a_in;
      acc_ff  <= acc_in;
      h1_ff   <= h1_in;
      h2_ff   <= h2_in;
      divd_ff <= divd_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      zero_ff <= zero_in;
      base_ff <= base_in;
      if (reset) begin
         state_ff <= F_IDLE;
         ph_ff    <= 2'd0;
         msel_ff  <= 1'b0;
         hsel_ff  <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         msel_ff  <= msel_in;
         hsel_ff  <= hsel_in;
         dcnt_ff  <= dcnt_in;
      end
   end
endmodule

[sv/bbf_back.sv]
// back end: bit store, probe sequencer and clearing pass
`include "blocked_bloom_filter_assert.svh"
module bbf_back #(
   parameter int MAX_BLOCKS       = 1024,
   parameter int BLOCK_SIZE_BYTES = 64,
   parameter int ENT_W            = 79
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [bbf_pkg::KCNT_W-1:0] k_eff,
   input  logic                      ent_empty,
   input  logic [ENT_W-1:0]          ent_data,
   output logic                      ent_pop,
   input  logic                      res_full,
   output logic                      res_push,
   output logic                      res_data,
   output logic                      clearing
);
   import bbf_pkg::*;

   localparam int WPB         = (BLOCK_SIZE_BYTES + 7) / 8;
   localparam int STORE_WORDS = MAX_BLOCKS * WPB;
   localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int BB          = BLOCK_SIZE_BYTES * 8;
   localparam int BIT_W       = $clog2(BB);
   localparam int Q_W         = RECIP_W + HALF_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / BB);

   localparam logic [2:0] B_CLEAR  = 3'd0;
   localparam logic [2:0] B_IDLE   = 3'd1;
   localparam logic [2:0] B_MUL    = 3'd2;
   localparam logic [2:0] B_ADDR   = 3'd3;
   localparam logic [2:0] B_DATA   = 3'd4;
   localparam logic [2:0] B_RESULT = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [AW-1:0]             clr_ff, clr_in;
   logic                      mode_ff, mode_in;
   logic [AW-1:0]             base_ff, base_in;
   logic [31:0]               pos_ff, pos_in, step_ff, step_in;
   logic [KCNT_W-1:0]         i_ff, i_in;
   logic [RECIP_W+HALF_W-1:0] prod_ff;
   logic [AW-1:0]             addr_ff;
   logic [5:0]                bsel_ff;
   logic                      res_ff, res_in;
   logic [63:0]               rd_data_ff;
   logic [63:0]               mem [STORE_WORDS];

   logic [Q_W-1:0]   q;
   logic [31:0]      r0, r;
   logic [BIT_W-1:0] bitpos;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic             rd_en, wr_en, last, hit;
   logic [63:0]      wr_data;

   assign clearing = (state_ff == B_CLEAR);
   assign ent_pop  = (state_ff == B_IDLE) && !ent_empty;
   assign res_push = (state_ff == B_RESULT) && !res_full;
   assign res_data = res_ff;

   always_comb begin
      // quotient estimate is exact or one short
      q       = prod_ff[RECIP_W+HALF_W-1:RECIP_SHIFT];
      r0      = pos_ff - 32'(32'(q) * BB);
      r       = (r0 >= 32'(BB)) ? r0 - 32'(BB) : r0;
      bitpos  = r[BIT_W-1:0];
      rd_addr = base_ff + AW'(bitpos >> 6);
      rd_en   = (state_ff == B_ADDR);
      hit     = rd_data_ff[bsel_ff];
      last    = (i_ff == k_eff - KCNT_W'(1));
      wr_en   = clearing || (state_ff == B_DATA && mode_ff == MODE_INSERT);
      wr_addr = clearing ? clr_ff : addr_ff;
      wr_data = clearing ? 64'd0 : (rd_data_ff | (64'd1 << bsel_ff));
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      mode_in  = mode_ff;
      base_in  = base_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      i_in     = i_ff;
      res_in   = res_ff;
      case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(STORE_WORDS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!ent_empty) begin
               mode_in = ent_data[ENT_W-1];
               base_in = ent_data[ENT_W-3 -: AW];
               pos_in  = ent_data[63:32];
               step_in = ent_data[31:0];
               i_in    = '0;
               if (ent_data[ENT_W-2]) begin
                  res_in   = 1'b0;
                  state_in = B_RESULT;
               end else if (k_eff == '0) begin
                  // no probe can fail
                  res_in   = (ent_data[ENT_W-1] == MODE_QUERY);
                  state_in = B_RESULT;
               end else begin
                  state_in = B_MUL;
               end
            end
         end
         B_MUL:  state_in = B_ADDR;
         B_ADDR: state_in = B_DATA;
         B_DATA: begin
            if (mode_ff == MODE_QUERY && !hit) begin
               res_in   = 1'b0;
               state_in = B_RESULT;
            end else if (last) begin
               res_in   = (mode_ff == MODE_QUERY);
               state_in = B_RESULT;
            end else begin
               i_in     = i_ff + KCNT_W'(1);
               pos_in   = pos_ff + step_ff;
               state_in = B_MUL;
            end
         end
         B_RESULT: begin
            if (!res_full) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         addr_ff    <= rd_addr;
         bsel_ff    <= bitpos[5:0];
      end
      prod_ff <= (RECIP_W + HALF_W)'(pos_ff) * (RECIP_W + HALF_W)'(RECIP);
      mode_ff <= mode_in;
      base_ff <= base_in;
      pos_ff  <= pos_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         i_ff     <= i_in;
      end
   end

   `BBF_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> state_ff == B_CLEAR, "reset did not start clearing")
   `BBF_ASSERT(a_read_before_use, clock, reset, state_ff == B_DATA |-> $past(state_ff) == B_ADDR, "store word used without a read")
   `BBF_ASSERT(a_query_no_write, clock, reset, (wr_en && !clearing) |-> mode_ff == MODE_INSERT, "query wrote the store")
   `BBF_ASSERT(a_result_then_idle, clock, reset, res_push |=> state_ff == B_IDLE, "result pushed but sequencer not idle")
endmodule

[sv/blocked_bloom_filter.sv]
// blocked bloom filter top level: register port, front end, queues, back end
// each word is hashed and its block found by division in the front end, then its bits are probed in the back end
// a new word is hashed while the back end probes the one before; the rate is set by the 64-step divider and the
//   single-port read-modify-write of the bit store
// reset: a clearing pass zeroes all MAX_BLOCKS*ceil(BLOCK_SIZE_BYTES/8) words of the store;
//   full stays high until it ends, register writes are taken throughout
module blocked_bloom_filter #(
   parameter int MAX_BLOCKS       = bbf_pkg::DEF_MAX_BLOCKS,
   parameter int BLOCK_SIZE_BYTES = bbf_pkg::DEF_BLOCK_SIZE_BYTES,
   parameter int MAX_HASHES       = bbf_pkg::DEF_MAX_HASHES
) (
   input  logic                          clock,
   input  logic                          reset,
   // input words
   input  logic                          push,
   output logic                          full,
   input  logic                          req_mode,
   input  logic [63:0]                   req_key,
   // result words
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_maybe_present,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bbf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bbf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bbf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import bbf_pkg::*;

   localparam int WPB         = (BLOCK_SIZE_BYTES + 7) / 8;
   localparam int STORE_WORDS = MAX_BLOCKS * WPB;
   localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   // mode, zero flag, block base, start, step
   localparam int ENT_W       = 2 + AW + 2 * HALF_W;

   logic [NB_W-1:0]   nb_ff;
   logic [NH_W-1:0]   nh_ff;
   logic [NB_W-1:0]   nb_eff;
   logic [KCNT_W-1:0] k_eff;
   logic              csr_wr;

   logic             front_busy, accept, clearing;
   logic             ent_push, ent_full, ent_pop, ent_empty;
   logic [ENT_W-1:0] ent_in, ent_out;
   logic             res_push, res_full, res_data;

   // register port, no wait states
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_NUM_HASHES) ? CSR_DATA_W'(nh_ff) : CSR_DATA_W'(nb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_ff <= NB_W'(1);
         nh_ff <= NH_W'(1);
      end else if (csr_wr) begin
         if (paddr[2] == REG_NUM_BLOCKS) begin
            nb_ff <= pwdata[NB_W-1:0];
         end else begin
            nh_ff <= pwdata[NH_W-1:0];
         end
      end
   end

   // counts above MAX_BLOCKS or MAX_HASHES saturate
   assign nb_eff = (32'(nb_ff) > MAX_BLOCKS) ? NB_W'(MAX_BLOCKS) : nb_ff;
   assign k_eff  = (32'(nh_ff) > MAX_HASHES) ? KCNT_W'(MAX_HASHES) : KCNT_W'(nh_ff);

   // input side stalls while hashing or while the store is being cleared
   assign full   = front_busy || clearing;
   assign accept = push && !full;

   bbf_front #(
      .MAX_BLOCKS       (MAX_BLOCKS),
      .BLOCK_SIZE_BYTES (BLOCK_SIZE_BYTES),
      .ENT_W            (ENT_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .mode     (req_mode),
      .key      (req_key),
      .nb_eff   (nb_eff),
      .busy     (front_busy),
      .ent_push (ent_push),
      .ent_full (ent_full),
      .ent_data (ent_in)
   );

   // decoupling queue between hashing and the store
   bbf_fifo #(
      .DATA_W (ENT_W)
   ) u_ent_q (
      .clock     (clock),
      .reset     (reset),
      .push      (ent_push),
      .push_data (ent_in),
      .full      (ent_full),
      .pop       (ent_pop),
      .pop_data  (ent_out),
      .empty     (ent_empty)
   );

   bbf_back #(
      .MAX_BLOCKS       (MAX_BLOCKS),
      .BLOCK_SIZE_BYTES (BLOCK_SIZE_BYTES),
      .ENT_W            (ENT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .k_eff     (k_eff),
      .ent_empty (ent_empty),
      .ent_data  (ent_out),
      .ent_pop   (ent_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data),
      .clearing  (clearing)
   );

   // result queue, lets the back end go on while a result waits
   bbf_fifo #(
      .DATA_W (1)
   ) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (rsp_maybe_present),
      .empty     (empty)
   );
endmodule

[test/testbench.sv]
// testbench for the blocked bloom filter: register setup, insert and query words, result check
`timescale 1ns / 1ps

module testbench;
   import bbf_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   // worst settle time after the last result: hashing plus 16 probes
   localparam int SETTLE_CYCLES = 160;
   localparam int LONG_HOLD = 8000;

   // expected answers and a private copy of the bit store
   class membership_board;
      logic [63:0] store [8192];
      bit          answers [$];
      int unsigned block_count;
      int unsigned probe_count;
      int          errors;

      function new();
         foreach (store[i]) store[i] = '0;
         block_count = 1;
         probe_count = 1;
         errors = 0;
      endfunction

      function logic [63:0] mix(logic [63:0] key, logic [63:0] seed);
         logic [63:0] z;
         z = (key ^ seed) + MIX_GOLDEN;
         z = (z ^ (z >> 30)) * MIX_C1;
         z = (z ^ (z >> 27)) * MIX_C2;
         return z ^ (z >> 31);
      endfunction

      // work out the answer of one accepted word and update the store
      function void note_word(logic mode, logic [63:0] key);
         int unsigned nb;
         int unsigned k;
         logic [63:0] h1;
         logic [63:0] h2;
         int unsigned base;
         logic [31:0] pos;
         logic [31:0] stride;
         int unsigned w;
         bit hit;
         nb = (block_count > 1024) ? 1024 : block_count;
         k = (probe_count > 16) ? 16 : probe_count;
         hit = 1'b1;
         if (nb == 0) begin
            answers.push_back(1'b0);
            return;
         end
         h1 = mix(key, SEED_BLOCK);
         h2 = mix(key, SEED_BITS);
         base = 32'((h1 % 64'(nb)) * 64'd8);
         stride = h2[63:32] | 32'd1;
         for (int i = 0; i < k; i++) begin
            pos = h2[31:0] + 32'(i) * stride;
            w = base + 32'(pos[8:6]);
            if (mode == MODE_QUERY) begin
               if (!store[w][pos[5:0]]) begin
                  hit = 1'b0;
                  break;
               end
            end else begin
               store[w][pos[5:0]] = 1'b1;
            end
         end
         answers.push_back(mode == MODE_QUERY && hit);
      endfunction

      function void check_word(logic got);
         bit want;
         if (answers.size() == 0) begin
            $error("result word with nothing expected: maybe_present=%0d", got);
            errors++;
            return;
         end
         want = answers.pop_front();
         if (got !== want) begin
            $error("maybe_present mismatch: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic push;
   logic full;
   logic req_mode;
   logic [63:0] req_key;
   logic empty;
   logic pop;
   logic rsp_maybe_present;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   membership_board board = new();
   logic [63:0] seen_keys [$];
   int  cycles;
   bit  quiet;        // no idling on either side
   bit  hold_request; // ask the receiver for one long hold-off

   blocked_bloom_filter uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_mode(req_mode), .req_key(req_key),
      .empty(empty), .pop(pop), .rsp_maybe_present(rsp_maybe_present),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("** blocked_bloom_filter: FAILED **");
         $finish;
      end
   end

   // receiver: check each popped word, stall in random bursts, one long hold-off
   initial begin : receiver
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) board.check_word(rsp_maybe_present);
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            stall--;
            pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // register write: setup cycle then access cycle
   task automatic write_reg(logic index, int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(index) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == REG_NUM_BLOCKS) board.block_count = value & 32'h7ff;
      else board.probe_count = value & 32'h1f;
   endtask

   // offer one word, with an occasional gap before it; push stays high between words
   task automatic send_word(logic mode, logic [63:0] key);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      push     <= 1'b1;
      req_mode <= mode;
      req_key  <= key;
      do @(posedge clock); while (full);
      board.note_word(mode, key);
      if (mode == MODE_INSERT) begin
         seen_keys.push_back(key);
         if (seen_keys.size() > 64) void'(seen_keys.pop_front());
      end
   endtask

   function automatic logic [63:0] pick_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // wait until every accepted word has been answered
   task automatic drain();
      while (board.answers.size() != 0) @(posedge clock);
   endtask

   // drain all results, let the back end settle, then set new register values
   task automatic set_phase(int unsigned nb, int unsigned nh);
      push <= 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(REG_NUM_BLOCKS, nb);
      write_reg(REG_NUM_HASHES, nh);
   endtask

   // random words: mostly inserts and queries of recently inserted keys
   task automatic random_words(int n);
      logic mode;
      logic [63:0] key;
      for (int i = 0; i < n; i++) begin
         mode = 1'($urandom_range(0, 1));
         if (mode == MODE_QUERY && seen_keys.size() > 0 && $urandom_range(0, 2) != 0)
            key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
         else
            key = pick_key();
         send_word(mode, key);
      end
   endtask

   initial begin
      cycles = 0;
      quiet = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      req_mode = MODE_INSERT;
      req_key = '0;
      pop = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, key extremes, insert then query
      send_word(MODE_QUERY, '0);
      send_word(MODE_INSERT, '0);
      send_word(MODE_QUERY, '0);
      send_word(MODE_INSERT, '1);
      send_word(MODE_QUERY, '1);
      send_word(MODE_QUERY, 64'h8000_0000_0000_0000);
      send_word(MODE_INSERT, 64'h8000_0000_0000_0001);
      send_word(MODE_QUERY, 64'h8000_0000_0000_0001);
      // zero block count: nothing stored, queries answer 0
      set_phase(0, 3);
      send_word(MODE_INSERT, 64'h0123_4567_89ab_cdef);
      send_word(MODE_QUERY, 64'h0123_4567_89ab_cdef);
      send_word(MODE_QUERY, '0);
      // zero hash count: every query answers 1
      set_phase(5, 0);
      send_word(MODE_INSERT, 64'hdead_beef_0000_0001);
      send_word(MODE_QUERY, 64'hfeed_face_cafe_f00d);
      // block and hash counts above the maximum saturate
      set_phase(2047, 31);
      send_word(MODE_INSERT, 64'h5555_aaaa_5555_aaaa);
      send_word(MODE_QUERY, 64'h5555_aaaa_5555_aaaa);
      send_word(MODE_QUERY, 64'haaaa_5555_aaaa_5555);
      set_phase(1024, 16);
      send_word(MODE_INSERT, '1);
      send_word(MODE_QUERY, '1);

      random_words(150);
      set_phase(1, 16);
      random_words(120);
      // long receiver hold-off so the block fills up and stalls its input
      set_phase(3, 2);
      hold_request = 1'b1;
      random_words(220);
      set_phase($urandom_range(1, 2047), $urandom_range(1, 31));
      random_words(150);
      set_phase(17, 4);
      random_words(200);
      set_phase(2, 1);
      quiet = 1'b1;
      random_words(190);
      push <= 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0) $display("** blocked_bloom_filter: PASSED **");
      else $display("** blocked_bloom_filter: FAILED **");
      $finish;
   end
endmodule
